// ===== design/imhq_pkg.sv =====
// Shared constants, codes and controller interface types for the indexed min-heap queue.
package imhq_pkg;
   localparam int ITEM_W = 12;
   localparam int CMD_W = 2;
   localparam int ST_W = 3;
   localparam int QC_W = 13;
   localparam int DEF_NUM_ITEMS = 4096;
   localparam int DEF_KEY_BITS = 40;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP = 2'd2;

   localparam logic [ST_W-1:0] ST_OK = 3'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL = 3'd2;
   localparam logic [ST_W-1:0] ST_ABSENT = 3'd3;
   localparam logic [ST_W-1:0] ST_DUP = 3'd4;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_CLEAR = 4'd0;
   localparam logic [OP_W-1:0] OP_IDLE = 4'd1;
   localparam logic [OP_W-1:0] OP_LOOK = 4'd2;
   localparam logic [OP_W-1:0] OP_POPL = 4'd3;
   localparam logic [OP_W-1:0] OP_UP = 4'd4;
   localparam logic [OP_W-1:0] OP_UPW = 4'd5;
   localparam logic [OP_W-1:0] OP_DOWN = 4'd6;
   localparam logic [OP_W-1:0] OP_DL = 4'd7;
   localparam logic [OP_W-1:0] OP_DR = 4'd8;
   localparam logic [OP_W-1:0] OP_PLACE = 4'd9;
   localparam logic [OP_W-1:0] OP_RESP = 4'd10;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic accept;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic look_go;
      logic look_pop;
      logic is_update;
      logic pop_more;
      logic up_top;
      logic up_swap;
      logic down_end;
      logic has_right;
      logic left_swap;
      logic dr_swap;
      logic rsp_free;
   } ctl_sts_type;
endpackage

// ===== design/imhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/imhq_ctrl.sv =====
// Sequencer for heap commands: clear pass, lookup, pop, sift up, sift down, place, response.
module imhq_ctrl import imhq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output ctl_cmd_type cmd,
   input  ctl_sts_type sts
);
   logic [OP_W-1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         OP_CLEAR: if (sts.clr_done) state_in = OP_IDLE;
         OP_IDLE: if (req_valid) state_in = OP_LOOK;
         OP_LOOK: begin
            if (!sts.look_go) state_in = OP_RESP;
            else if (sts.look_pop) state_in = OP_POPL;
            else state_in = OP_UP;
         end
         OP_POPL: state_in = sts.pop_more ? OP_DOWN : OP_RESP;
         OP_UP: begin
            if (!sts.up_top) state_in = OP_UPW;
            else state_in = sts.is_update ? OP_DOWN : OP_PLACE;
         end
         OP_UPW: begin
            if (sts.up_swap) state_in = OP_UP;
            else state_in = sts.is_update ? OP_DOWN : OP_PLACE;
         end
         OP_DOWN: state_in = sts.down_end ? OP_PLACE : OP_DL;
         OP_DL: begin
            if (sts.has_right) state_in = OP_DR;
            else state_in = sts.left_swap ? OP_DOWN : OP_PLACE;
         end
         OP_DR: state_in = sts.dr_swap ? OP_DOWN : OP_PLACE;
         OP_PLACE: state_in = OP_RESP;
         OP_RESP: if (sts.rsp_free) state_in = OP_IDLE;
         default: state_in = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != OP_IDLE);
   assign cmd.op = state_ff;
   assign cmd.accept = (state_ff == OP_IDLE) && req_valid;
endmodule

// ===== design/imhq_datapath.sv =====
// Heap, position and key stores with the slot arithmetic and key compares.
module imhq_datapath import imhq_pkg::*; #(
   parameter int NUM_ITEMS = DEF_NUM_ITEMS,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output ctl_sts_type         sts,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [ITEM_W-1:0]   req_item,
   input  logic [KEY_BITS-1:0] req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ITEM_W-1:0]   rsp_out_item,
   output logic [KEY_BITS-1:0] rsp_out_key,
   output logic [ST_W-1:0]     rsp_status,
   output logic [QC_W-1:0]     rsp_queued_count
);
   localparam int IW = $clog2(NUM_ITEMS);
   localparam int SW = $clog2(NUM_ITEMS + 1);
   localparam int LW = SW + 1;
   localparam int HDW = ITEM_W + KEY_BITS;

   // request and walk registers
   logic [CMD_W-1:0]    cmd_ff;
   logic [ITEM_W-1:0]   item_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                item_ok_ff;
   logic [SW-1:0]       cnt_ff, cnt_in;
   logic [SW-1:0]       s_ff, s_in;
   logic [ITEM_W-1:0]   mv_item_ff, mv_item_in;
   logic [KEY_BITS-1:0] mv_key_ff, mv_key_in;
   logic [ITEM_W-1:0]   lt_item_ff;
   logic [KEY_BITS-1:0] lt_key_ff;
   logic [ITEM_W-1:0]   res_item_ff, res_item_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   logic [ST_W-1:0]     res_st_ff, res_st_in;
   logic [IW-1:0]       clr_cnt_ff;
   logic                rsp_valid_ff;
   logic [ITEM_W-1:0]   rsp_item_ff;
   logic [KEY_BITS-1:0] rsp_key_ff;
   logic [ST_W-1:0]     rsp_st_ff;
   logic [QC_W-1:0]     rsp_qc_ff;

   // memory ports
   logic           heap_we, pos_we, key_we;
   logic [IW-1:0]  heap_wa, pos_wa, heap_ra, pos_ra;
   logic [HDW-1:0] heap_wd, heap_q;
   logic [SW-1:0]  pos_wd, pos_q;
   logic [KEY_BITS-1:0] key_q;

   logic [ITEM_W-1:0]   hq_item;
   logic [KEY_BITS-1:0] hq_key;
   logic [LW-1:0]       left_slot;
   logic [SW-1:0]       half_slot;
   logic                go_l, go_r, pick_r, rsp_load;

   assign hq_item = heap_q[HDW-1:KEY_BITS];
   assign hq_key = heap_q[KEY_BITS-1:0];
   assign left_slot = {s_ff, 1'b0};
   assign half_slot = {1'b0, s_ff[SW-1:1]};
   assign go_l = mv_key_ff > lt_key_ff;
   assign go_r = mv_key_ff > hq_key;
   assign pick_r = hq_key < lt_key_ff;
   assign rsp_load = (cmd.op == OP_RESP) && sts.rsp_free;

   always_comb begin
      sts = '0;
      sts.clr_done = clr_cnt_ff == IW'(NUM_ITEMS - 1);
      sts.is_update = cmd_ff == CMD_UPDATE;
      sts.look_pop = cmd_ff == CMD_POP;
      sts.pop_more = cnt_ff != SW'(1);
      sts.up_top = s_ff == SW'(1);
      sts.up_swap = mv_key_ff < hq_key;
      sts.down_end = left_slot > LW'(cnt_ff);
      sts.has_right = (left_slot + LW'(1)) <= LW'(cnt_ff);
      sts.left_swap = mv_key_ff > hq_key;
      sts.dr_swap = go_l || go_r;
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;

      heap_we = 1'b0;
      pos_we = 1'b0;
      key_we = 1'b0;
      heap_wa = IW'(s_ff - SW'(1));
      heap_wd = {mv_item_ff, mv_key_ff};
      pos_wa = IW'(mv_item_ff);
      pos_wd = s_ff;
      heap_ra = '0;
      pos_ra = IW'(req_item);
      cnt_in = cnt_ff;
      s_in = s_ff;
      mv_item_in = mv_item_ff;
      mv_key_in = mv_key_ff;
      res_item_in = res_item_ff;
      res_key_in = res_key_ff;
      res_st_in = res_st_ff;

      unique case (cmd.op)
         OP_CLEAR: begin
            pos_we = 1'b1;
            pos_wa = clr_cnt_ff;
            pos_wd = '0;
         end
         OP_LOOK: begin
            res_item_in = item_ff;
            res_key_in = key_ff;
            res_st_in = ST_OK;
            mv_item_in = item_ff;
            mv_key_in = key_ff;
            priority case (cmd_ff)
               CMD_INSERT: begin
                  if (!item_ok_ff) begin
                     res_st_in = ST_ABSENT;
                     res_key_in = '0;
                  end else if (pos_q != '0) begin
                     res_st_in = ST_DUP;
                     res_key_in = key_q;
                  end else if (cnt_ff == SW'(NUM_ITEMS)) begin
                     res_st_in = ST_FULL;
                  end else begin
                     sts.look_go = 1'b1;
                     key_we = 1'b1;
                     cnt_in = cnt_ff + SW'(1);
                     s_in = cnt_ff + SW'(1);
                  end
               end
               CMD_UPDATE: begin
                  if (!item_ok_ff || pos_q == '0 || pos_q > cnt_ff) begin
                     res_st_in = ST_ABSENT;
                     res_key_in = '0;
                  end else begin
                     sts.look_go = 1'b1;
                     key_we = 1'b1;
                     s_in = pos_q;
                  end
               end
               CMD_POP: begin
                  if (cnt_ff == '0) begin
                     res_st_in = ST_EMPTY;
                     res_item_in = '0;
                     res_key_in = '0;
                  end else begin
                     sts.look_go = 1'b1;
                     res_item_in = hq_item;
                     res_key_in = hq_key;
                     heap_ra = IW'(cnt_ff - SW'(1));
                  end
               end
               default: begin
                  res_item_in = '0;
                  res_key_in = '0;
               end
            endcase
         end
         OP_POPL: begin
            // last entry arrives; mark popped item absent
            pos_we = 1'b1;
            pos_wa = IW'(res_item_ff);
            pos_wd = '0;
            cnt_in = cnt_ff - SW'(1);
            s_in = SW'(1);
            mv_item_in = hq_item;
            mv_key_in = hq_key;
         end
         OP_UP: heap_ra = IW'(half_slot - SW'(1));
         OP_UPW: begin
            if (mv_key_ff < hq_key) begin
               heap_we = 1'b1;
               heap_wd = heap_q;
               pos_we = 1'b1;
               pos_wa = IW'(hq_item);
               s_in = half_slot;
            end
         end
         OP_DOWN: heap_ra = IW'(left_slot - LW'(1));
         OP_DL: begin
            heap_ra = IW'(left_slot);
            if (!sts.has_right && sts.left_swap) begin
               heap_we = 1'b1;
               heap_wd = heap_q;
               pos_we = 1'b1;
               pos_wa = IW'(hq_item);
               s_in = SW'(left_slot);
            end
         end
         OP_DR: begin
            if (go_l || go_r) begin
               heap_we = 1'b1;
               pos_we = 1'b1;
               if (pick_r) begin
                  heap_wd = heap_q;
                  pos_wa = IW'(hq_item);
                  s_in = SW'(left_slot + LW'(1));
               end else begin
                  heap_wd = {lt_item_ff, lt_key_ff};
                  pos_wa = IW'(lt_item_ff);
                  s_in = SW'(left_slot);
               end
            end
         end
         OP_PLACE: begin
            heap_we = 1'b1;
            pos_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.op == OP_CLEAR) clr_cnt_ff <= clr_cnt_ff + IW'(1);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff <= req_command;
         item_ff <= req_item;
         key_ff <= req_key;
         item_ok_ff <= {20'd0, req_item} < 32'(NUM_ITEMS);
      end
      if (cmd.op == OP_DL) begin
         lt_item_ff <= hq_item;
         lt_key_ff <= hq_key;
      end
      s_ff <= s_in;
      mv_item_ff <= mv_item_in;
      mv_key_ff <= mv_key_in;
      res_item_ff <= res_item_in;
      res_key_ff <= res_key_in;
      res_st_ff <= res_st_in;
      if (rsp_load) begin
         rsp_item_ff <= res_item_ff;
         rsp_key_ff <= res_key_ff;
         rsp_st_ff <= res_st_ff;
         rsp_qc_ff <= QC_W'(cnt_ff);
      end
   end

   imhq_ram #(.WIDTH(HDW), .DEPTH(NUM_ITEMS)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_q)
   );

   imhq_ram #(.WIDTH(SW), .DEPTH(NUM_ITEMS)) u_pos (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_wd),
      .rd_addr(pos_ra), .rd_data(pos_q)
   );

   imhq_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_ITEMS)) u_keys (
      .clock(clock), .wr_en(key_we), .wr_addr(IW'(item_ff)), .wr_data(key_ff),
      .rd_addr(pos_ra), .rd_data(key_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_item = rsp_item_ff;
   assign rsp_out_key = rsp_key_ff;
   assign rsp_status = rsp_st_ff;
   assign rsp_queued_count = rsp_qc_ff;
endmodule

// ===== design/indexed_min_heap_queue.sv =====
// Indexed binary min-heap queue: top level joining sequencer and datapath.
// Usage: each req_ item (command, item, key) yields one rsp_ item with the
// affected item, its key, a status code and the queue size afterward.
// Insert, update-key and pop-minimum are supported; bad cases are reported
// in rsp_status (empty, full, absent, already queued) and change nothing.
// An item is taken when req_valid is high and req_stall low; req_stall is
// high while a command is being worked on.
// Steps: a lookup, then each sift-up level reads the parent and then
// compares/moves; each sift-down level reads the left child, reads the
// right child and then compares/moves (with no right child it compares
// after the left read); then the entry is placed and the response given.
// An update sifts up, then down; the single read port of the heap RAM makes the reads of a level go in turn.
// One command is in flight at a time.
// Reset: a clearing pass writes the position store, one entry per cycle,
// for all NUM_ITEMS entries, with req_stall high; the heap then is empty.
// A stalled response holds in the output register; the next item is
// still accepted and its result waits until the register frees up.
module indexed_min_heap_queue import imhq_pkg::*; #(
   parameter int NUM_ITEMS = DEF_NUM_ITEMS,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [ITEM_W-1:0]   req_item,
   input  logic [KEY_BITS-1:0] req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ITEM_W-1:0]   rsp_out_item,
   output logic [KEY_BITS-1:0] rsp_out_key,
   output logic [ST_W-1:0]     rsp_status,
   output logic [QC_W-1:0]     rsp_queued_count
);
   ctl_cmd_type cmd_w;
   ctl_sts_type sts_w;

   imhq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .cmd(cmd_w), .sts(sts_w)
   );

   imhq_datapath #(.NUM_ITEMS(NUM_ITEMS), .KEY_BITS(KEY_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd_w), .sts(sts_w),
      .req_command(req_command), .req_item(req_item), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_item(rsp_out_item),
      .rsp_out_key(rsp_out_key), .rsp_status(rsp_status),
      .rsp_queued_count(rsp_queued_count)
   );

`ifndef SYNTHESIS
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (cmd_w.op == OP_LOOK))
      else $error("accepted item did not start lookup");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_DUP))
      else $error("unknown status code");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_queued_count) <= 32'(NUM_ITEMS)))
      else $error("queue count beyond capacity");
`endif
endmodule
